// ----- rtl/cpsp_pkg.sv -----
// Shared constants, register codes and the job record for the cascaded
// position / speed PID block. No dependencies.
`timescale 1ns / 1ps

package cpsp_pkg;

  // Field and datapath widths
  localparam int TICK_W    = 6;
  localparam int DELTA_W   = 12;
  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 15;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 18;
  localparam int SUM_W     = 32;
  localparam int ACC_W     = 50;
  localparam int FRAC_W    = 12;
  localparam int CFG_IDX_W = 3;

  // Default periods and queue size
  localparam int INNER_PERIOD_DEF = 40;
  localparam int OUTER_PERIOD_DEF = 40;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Configuration reset values
  localparam logic signed [GAIN_W-1:0] SPEED_KP_RST = 16'sd1229;
  localparam logic signed [GAIN_W-1:0] SPEED_KI_RST = 16'sd1229;
  localparam logic signed [GAIN_W-1:0] SPEED_KD_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] POS_KP_RST   = 16'sd1229;
  localparam logic signed [GAIN_W-1:0] POS_KI_RST   = 16'sd0;
  localparam logic signed [GAIN_W-1:0] POS_KD_RST   = 16'sd1638;
  localparam logic signed [DATA_W-1:0] GOAL_RST     = 16'sd250;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST    = 15'd300;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_KP = 3'd0,
    REG_SPEED_KI = 3'd1,
    REG_SPEED_KD = 3'd2,
    REG_POS_KP   = 3'd3,
    REG_POS_KI   = 3'd4,
    REG_POS_KD   = 3'd5,
    REG_GOAL     = 3'd6,
    REG_LIMIT    = 3'd7
  } reg_idx_t;

  // One period boundary handed from front to back
  typedef struct packed {
    logic                     inner_run;
    logic                     outer_run;
    logic signed [DATA_W-1:0] speed;
    logic signed [DATA_W-1:0] position;
  } job_t;

endpackage

// ----- rtl/cpsp_in_if.sv -----
// Input channel: one encoder tick per request, valid/ready handshake.
// Depends on cpsp_pkg.
`timescale 1ns / 1ps

interface cpsp_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [cpsp_pkg::DELTA_W-1:0]       encoder_delta;

  modport source (output valid, output encoder_delta, input ready);
  modport sink   (input valid, input encoder_delta, output ready);
endinterface

// ----- rtl/cpsp_out_if.sv -----
// Result channel: drive and measurements once per inner period.
// Depends on cpsp_pkg.
`timescale 1ns / 1ps

interface cpsp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cpsp_pkg::DATA_W-1:0]  motor_drive;
  logic signed [cpsp_pkg::DATA_W-1:0]  measured_speed;
  logic signed [cpsp_pkg::DATA_W-1:0]  measured_position;
  logic signed [cpsp_pkg::DATA_W-1:0]  speed_setpoint;

  modport source (output valid, output motor_drive, output measured_speed,
                  output measured_position, output speed_setpoint, input ready);
  modport sink   (input valid, input motor_drive, input measured_speed,
                  input measured_position, input speed_setpoint, output ready);
endinterface

// ----- rtl/cascaded_position_speed_pid.sv -----
// Cascaded position / speed PID controller.
// Input channel in_chan: one request per encoder timer tick, carrying the
// signed counts of that tick. Every INNER_PERIOD ticks the speed loop runs and
// one result is sent on out_chan: negated clamped drive, summed speed,
// wrapped position and the speed setpoint used. Every OUTER_PERIOD ticks the
// position loop runs and sets the next speed setpoint.
// Throughput: one tick per cycle while the job queue has room. The front
// end never waits on the math; at a period boundary it queues a job for the
// back end, which runs PREP, MUL, ADD and DONE for each loop the job runs.
// The job queue fills, and the input stalls, only if boundaries come closer
// than the back end finishes jobs on average. A result is registered in DONE,
// after any queued jobs ahead of its own.
// Reset (rst_n low, synchronous): counters, sums, position, setpoint and
// loop history clear, gains and limits return to their defaults.
// A stalled receiver holds the result in the output register; the back end
// then pauses at its next speed result and ticks keep being taken until the
// job queue is full. Configuration is written on cfg_we, one register a cycle.
// Depends on cpsp_pkg, cpsp_in_if, cpsp_out_if, cpsp_front, cpsp_queue, cpsp_back.
`timescale 1ns / 1ps

module cascaded_position_speed_pid #(
  parameter int INNER_PERIOD = cpsp_pkg::INNER_PERIOD_DEF,
  parameter int OUTER_PERIOD = cpsp_pkg::OUTER_PERIOD_DEF,
  parameter int QUEUE_DEPTH  = cpsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cpsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpsp_pkg::DATA_W-1:0]     cfg_data,
  cpsp_in_if.sink                         in_chan,
  cpsp_out_if.source                      out_chan
);

  logic           push, full, pop_valid, pop;
  cpsp_pkg::job_t push_job, pop_job;

  // Accept ticks and detect period boundaries
  cpsp_front #(
    .INNER_PERIOD (INNER_PERIOD),
    .OUTER_PERIOD (OUTER_PERIOD)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (full),
    .q_push  (push),
    .q_job   (push_job)
  );

  // Decouple the two ends
  cpsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop       (pop)
  );

  // Run the loops and drive results
  cpsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (pop_valid),
    .q_job     (pop_job),
    .q_pop     (pop),
    .out_chan  (out_chan)
  );

endmodule

// ----- rtl/cpsp_front.sv -----
// Front end: takes encoder ticks, sums speed, tracks position and the two
// period counters, and pushes a job at each period boundary. Uses cpsp_pkg.
`timescale 1ns / 1ps

module cpsp_front #(
  parameter int INNER_PERIOD = cpsp_pkg::INNER_PERIOD_DEF,
  parameter int OUTER_PERIOD = cpsp_pkg::OUTER_PERIOD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cpsp_in_if.sink           in_chan,
  input  logic              q_full,
  output logic              q_push,
  output cpsp_pkg::job_t    q_job
);

  logic [cpsp_pkg::TICK_W-1:0]        inner_cnt_r, inner_cnt_nxt;
  logic [cpsp_pkg::TICK_W-1:0]        outer_cnt_r, outer_cnt_nxt;
  logic signed [cpsp_pkg::DATA_W-1:0] speed_acc_r, speed_acc_nxt;
  logic signed [cpsp_pkg::DATA_W-1:0] position_r, position_nxt;
  logic signed [cpsp_pkg::DATA_W-1:0] delta_ext;
  logic signed [cpsp_pkg::DATA_W-1:0] speed_sum;
  logic [cpsp_pkg::TICK_W-1:0]        inner_inc, outer_inc;
  logic                               inner_fire, outer_fire;
  logic                               accept;

  // Take a tick whenever the job queue has room
  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  // Sum this tick into the speed and advance both counters
  always_comb begin
    delta_ext  = {{(cpsp_pkg::DATA_W - cpsp_pkg::DELTA_W){in_chan.encoder_delta[cpsp_pkg::DELTA_W-1]}},
                  in_chan.encoder_delta};
    speed_sum  = speed_acc_r + delta_ext;
    inner_inc  = inner_cnt_r + 1'b1;
    outer_inc  = outer_cnt_r + 1'b1;
    inner_fire = (inner_inc == cpsp_pkg::TICK_W'(INNER_PERIOD));
    outer_fire = (outer_inc == cpsp_pkg::TICK_W'(OUTER_PERIOD));

    inner_cnt_nxt = inner_fire ? '0 : inner_inc;
    outer_cnt_nxt = outer_fire ? '0 : outer_inc;
    speed_acc_nxt = inner_fire ? '0 : speed_sum;
    position_nxt  = inner_fire ? position_r + speed_sum : position_r;
  end

  // Hand a job to the back end at any period boundary
  assign q_push             = accept && (inner_fire || outer_fire);
  assign q_job.inner_run    = inner_fire;
  assign q_job.outer_run    = outer_fire;
  assign q_job.speed        = speed_sum;
  assign q_job.position     = position_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_cnt_r <= '0;
      outer_cnt_r <= '0;
      speed_acc_r <= '0;
      position_r  <= '0;
    end else if (accept) begin
      inner_cnt_r <= inner_cnt_nxt;
      outer_cnt_r <= outer_cnt_nxt;
      speed_acc_r <= speed_acc_nxt;
      position_r  <= position_nxt;
    end
  end

endmodule

// ----- rtl/cpsp_queue.sv -----
// Short job queue between the front and back ends, flip-flop storage.
// Uses cpsp_pkg::job_t.
`timescale 1ns / 1ps

module cpsp_queue #(
  parameter int DEPTH = cpsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cpsp_pkg::job_t    push_job,
  output logic              full,
  output logic              pop_valid,
  output cpsp_pkg::job_t    pop_job,
  input  logic              pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cpsp_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/cpsp_back.sv -----
// Back end: configuration registers and a sequenced PID datapath that runs
// the speed loop, position loop or both per job, speed first. Uses cpsp_pkg.
`timescale 1ns / 1ps

module cpsp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cpsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpsp_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                q_valid,
  input  cpsp_pkg::job_t                      q_job,
  output logic                                q_pop,
  cpsp_out_if.source                          out_chan
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  localparam int Q_W = cpsp_pkg::ACC_W - cpsp_pkg::FRAC_W;

  // Configuration
  logic signed [cpsp_pkg::GAIN_W-1:0] speed_kp_r, speed_ki_r, speed_kd_r;
  logic signed [cpsp_pkg::GAIN_W-1:0] pos_kp_r, pos_ki_r, pos_kd_r;
  logic signed [cpsp_pkg::DATA_W-1:0] goal_r;
  logic [cpsp_pkg::LIMIT_W-1:0]       limit_r;

  // Loop state
  state_t                             state_r, state_nxt;
  cpsp_pkg::job_t                     job_r;
  logic                               sel_outer_r;
  logic signed [cpsp_pkg::DATA_W-1:0] speed_target_r;
  logic signed [cpsp_pkg::ERR_W-1:0]  speed_prev_r, pos_prev_r;
  logic signed [cpsp_pkg::SUM_W-1:0]  speed_sum_r, pos_sum_r;

  // Datapath pipeline registers
  logic signed [cpsp_pkg::ERR_W-1:0]  op_err_r;
  logic signed [cpsp_pkg::DIFF_W-1:0] op_diff_r;
  logic signed [cpsp_pkg::SUM_W-1:0]  op_sum_r;
  logic signed [cpsp_pkg::ERR_W+cpsp_pkg::GAIN_W-1:0]  p_kp_r;
  logic signed [cpsp_pkg::SUM_W+cpsp_pkg::GAIN_W-1:0]  p_ki_r;
  logic signed [cpsp_pkg::DIFF_W+cpsp_pkg::GAIN_W-1:0] p_kd_r;
  logic signed [cpsp_pkg::ACC_W-1:0]  acc_r;

  // Output register
  logic                               out_valid_r, out_valid_nxt;
  logic signed [cpsp_pkg::DATA_W-1:0] out_drive_r, out_speed_r, out_pos_r, out_setp_r;

  // Combinational operands
  logic signed [cpsp_pkg::DATA_W-1:0] tgt, act;
  logic signed [cpsp_pkg::GAIN_W-1:0] kp, ki, kd;
  logic signed [cpsp_pkg::ERR_W-1:0]  prev;
  logic signed [cpsp_pkg::SUM_W-1:0]  sum_old, sum_new;
  logic signed [cpsp_pkg::ERR_W-1:0]  err;
  logic signed [cpsp_pkg::SUM_W:0]    sum_ext;
  logic signed [cpsp_pkg::DIFF_W-1:0] diff;
  logic signed [cpsp_pkg::ACC_W-1:0]  rnd;
  logic signed [Q_W-1:0]              q_val, lim_pos, lim_neg;
  logic signed [cpsp_pkg::DATA_W-1:0] drive;
  logic                               out_free, out_write;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_kp_r <= cpsp_pkg::SPEED_KP_RST;
      speed_ki_r <= cpsp_pkg::SPEED_KI_RST;
      speed_kd_r <= cpsp_pkg::SPEED_KD_RST;
      pos_kp_r   <= cpsp_pkg::POS_KP_RST;
      pos_ki_r   <= cpsp_pkg::POS_KI_RST;
      pos_kd_r   <= cpsp_pkg::POS_KD_RST;
      goal_r     <= cpsp_pkg::GOAL_RST;
      limit_r    <= cpsp_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cpsp_pkg::reg_idx_t'(cfg_index))
        cpsp_pkg::REG_SPEED_KP: speed_kp_r <= cfg_data;
        cpsp_pkg::REG_SPEED_KI: speed_ki_r <= cfg_data;
        cpsp_pkg::REG_SPEED_KD: speed_kd_r <= cfg_data;
        cpsp_pkg::REG_POS_KP:   pos_kp_r   <= cfg_data;
        cpsp_pkg::REG_POS_KI:   pos_ki_r   <= cfg_data;
        cpsp_pkg::REG_POS_KD:   pos_kd_r   <= cfg_data;
        cpsp_pkg::REG_GOAL:     goal_r     <= cfg_data;
        cpsp_pkg::REG_LIMIT:    limit_r    <= cfg_data[cpsp_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Select the operands of the loop being run
  always_comb begin
    tgt     = sel_outer_r ? goal_r       : speed_target_r;
    act     = sel_outer_r ? job_r.position : job_r.speed;
    kp      = sel_outer_r ? pos_kp_r     : speed_kp_r;
    ki      = sel_outer_r ? pos_ki_r     : speed_ki_r;
    kd      = sel_outer_r ? pos_kd_r     : speed_kd_r;
    prev    = sel_outer_r ? pos_prev_r   : speed_prev_r;
    sum_old = sel_outer_r ? pos_sum_r    : speed_sum_r;
  end

  // Error, saturating integral and difference
  always_comb begin
    err     = {tgt[cpsp_pkg::DATA_W-1], tgt} - {act[cpsp_pkg::DATA_W-1], act};
    sum_ext = {sum_old[cpsp_pkg::SUM_W-1], sum_old}
            + {{(cpsp_pkg::SUM_W + 1 - cpsp_pkg::ERR_W){err[cpsp_pkg::ERR_W-1]}}, err};
    if (ki == '0) begin
      sum_new = '0;
    end else if (sum_ext[cpsp_pkg::SUM_W] != sum_ext[cpsp_pkg::SUM_W-1]) begin
      sum_new = sum_ext[cpsp_pkg::SUM_W] ? {1'b1, {(cpsp_pkg::SUM_W-1){1'b0}}}
                                         : {1'b0, {(cpsp_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_new = sum_ext[cpsp_pkg::SUM_W-1:0];
    end
    diff = {err[cpsp_pkg::ERR_W-1], err} - {prev[cpsp_pkg::ERR_W-1], prev};
  end

  // Round to nearest, then clamp to the symmetric limit
  always_comb begin
    rnd     = acc_r + cpsp_pkg::ACC_W'(2048);
    q_val   = rnd[cpsp_pkg::ACC_W-1:cpsp_pkg::FRAC_W];
    lim_pos = {{(Q_W - cpsp_pkg::LIMIT_W){1'b0}}, limit_r};
    lim_neg = -lim_pos;
    if (q_val > lim_pos) begin
      drive = lim_pos[cpsp_pkg::DATA_W-1:0];
    end else if (q_val < lim_neg) begin
      drive = lim_neg[cpsp_pkg::DATA_W-1:0];
    end else begin
      drive = q_val[cpsp_pkg::DATA_W-1:0];
    end
  end

  assign out_free  = !out_valid_r || out_chan.ready;
  assign out_write = (state_r == ST_DONE) && !sel_outer_r && out_free;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;

  // Sequence each job: speed loop, position loop or both, speed first
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (sel_outer_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          state_nxt = job_r.outer_run ? ST_PREP : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on a new result, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_write) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sel_outer_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      speed_target_r <= '0;
      speed_prev_r   <= '0;
      speed_sum_r    <= '0;
      pos_prev_r     <= '0;
      pos_sum_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        sel_outer_r <= !q_job.inner_run;
      end else if (state_r == ST_DONE && !sel_outer_r && out_free) begin
        sel_outer_r <= job_r.outer_run;
      end
      if (state_r == ST_PREP) begin
        if (sel_outer_r) begin
          pos_prev_r <= err;
          pos_sum_r  <= sum_new;
        end else begin
          speed_prev_r <= err;
          speed_sum_r  <= sum_new;
        end
      end
      if (state_r == ST_DONE && sel_outer_r) begin
        speed_target_r <= drive;
      end
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (state_r == ST_PREP) begin
      op_err_r  <= err;
      op_diff_r <= diff;
      op_sum_r  <= sum_new;
    end
    if (state_r == ST_MUL) begin
      p_kp_r <= kp * op_err_r;
      p_ki_r <= ki * op_sum_r;
      p_kd_r <= kd * op_diff_r;
    end
    if (state_r == ST_ADD) begin
      acc_r <= cpsp_pkg::ACC_W'(p_kp_r) + cpsp_pkg::ACC_W'(p_ki_r) + cpsp_pkg::ACC_W'(p_kd_r);
    end
    if (out_write) begin
      out_drive_r <= -drive;
      out_speed_r <= job_r.speed;
      out_pos_r   <= job_r.position;
      out_setp_r  <= speed_target_r;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.motor_drive       = out_drive_r;
  assign out_chan.measured_speed    = out_speed_r;
  assign out_chan.measured_position = out_pos_r;
  assign out_chan.speed_setpoint    = out_setp_r;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for cascaded_position_speed_pid: random encoder ticks in,
// drive reports checked field by field against a cycle-free loop predictor.
// Depends on cpsp_pkg, cpsp_in_if, cpsp_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import cpsp_pkg::*;

  localparam int INNER_TICKS    = INNER_PERIOD_DEF;
  localparam int OUTER_TICKS    = OUTER_PERIOD_DEF;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_CAP      = 40;
  localparam int DELTA_MAX      = (1 << (DELTA_W - 1)) - 1;
  localparam int DELTA_MIN      = -(1 << (DELTA_W - 1));
  localparam longint SUM_MAX    = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN    = -(longint'(1) <<< (SUM_W - 1));
  localparam int EDGE_DELTAS [20] = '{2047, -2048, 0, -1, 1, 1365, -1366, 2047, 2047,
                                      -2048, -2048, 0, 1024, -1024, 512, -513, 2047,
                                      -2048, 1, -1};

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] speed;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] setpoint;
  } drive_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  cpsp_in_if  tick_if();
  cpsp_out_if report_if();

  cascaded_position_speed_pid DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (tick_if),
    .out_chan  (report_if)
  );

  // Predictor state: register copy and both loops
  logic signed [DATA_W-1:0] ctrl_regs [8];
  int                       inner_count;
  int                       outer_count;
  logic signed [DATA_W-1:0] speed_sum;
  logic signed [DATA_W-1:0] model_position;
  logic signed [DATA_W-1:0] speed_goal;
  logic signed [ERR_W-1:0]  speed_prev_err;
  logic signed [ERR_W-1:0]  pos_prev_err;
  logic signed [SUM_W-1:0]  speed_int;
  logic signed [SUM_W-1:0]  pos_int;

  logic signed [DELTA_W-1:0] pending_ticks [$];
  drive_report_t             pending_reports [$];
  drive_report_t             want_report;

  bit in_gaps_on;
  bit out_stalls_on;
  bit in_taken;
  int in_gap;
  int out_hold;
  int idle_cycles;
  int error_count;
  int ticks_taken;
  int reports_seen;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic signed [DATA_W-1:0] got,
                             input logic signed [DATA_W-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("report %0d %s got %0d want %0d", reports_seen, name, got,
                              want));
  endtask

  // One PID step: error, integral (cleared on zero ki), rounding, clamp
  task automatic run_pid(input longint target, input longint actual, input longint kp,
                         input longint ki, input longint kd,
                         inout logic signed [ERR_W-1:0] prev,
                         inout logic signed [SUM_W-1:0] integ,
                         output logic signed [DATA_W-1:0] result);
    longint err, s, acc, y, lim;
    err = target - actual;
    lim = ctrl_regs[REG_LIMIT][LIMIT_W-1:0];
    if (ki == 0) begin
      integ = '0;
    end else begin
      s = longint'(integ) + err;
      if (s > SUM_MAX) s = SUM_MAX;
      if (s < SUM_MIN) s = SUM_MIN;
      integ = s[SUM_W-1:0];
    end
    acc = kp * err + ki * longint'(integ) + kd * (err - longint'(prev));
    prev = err[ERR_W-1:0];
    y = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    if (y > lim) y = lim;
    if (y < -lim) y = -lim;
    result = y[DATA_W-1:0];
  endtask

  // Advance the loops by one accepted tick; queue a report at each inner period
  task automatic advance_tick(input logic signed [DELTA_W-1:0] delta);
    drive_report_t rpt;
    logic signed [DATA_W-1:0] loop_out;
    speed_sum = speed_sum + delta;
    inner_count = (inner_count + 1) % 64;
    if (inner_count >= INNER_TICKS) begin
      rpt.speed = speed_sum;
      rpt.setpoint = speed_goal;
      inner_count = 0;
      speed_sum = '0;
      model_position = model_position + rpt.speed;
      rpt.position = model_position;
      run_pid(speed_goal, rpt.speed, ctrl_regs[REG_SPEED_KP], ctrl_regs[REG_SPEED_KI],
              ctrl_regs[REG_SPEED_KD], speed_prev_err, speed_int, loop_out);
      rpt.drive = -loop_out;
      pending_reports.push_back(rpt);
    end
    outer_count = (outer_count + 1) % 64;
    if (outer_count >= OUTER_TICKS) begin
      outer_count = 0;
      run_pid(ctrl_regs[REG_GOAL], model_position, ctrl_regs[REG_POS_KP],
              ctrl_regs[REG_POS_KI], ctrl_regs[REG_POS_KD], pos_prev_err, pos_int,
              loop_out);
      speed_goal = loop_out;
    end
  endtask

  // Driver: present ticks and result-side ready at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!tick_if.valid || in_taken) begin
        if (in_gap > 0) begin
          tick_if.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_ticks.size() > 0) begin
          tick_if.valid <= 1'b1;
          tick_if.encoder_delta <= pending_ticks.pop_front();
          in_gap <= in_gaps_on ? pick_gap() : 0;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
      if (out_hold > 0) begin
        report_if.ready <= 1'b0;
        out_hold <= out_hold - 1;
      end else begin
        report_if.ready <= 1'b1;
        out_hold <= out_stalls_on ? pick_gap() : 0;
      end
    end
  end

  // Monitor: sample both channels at the rising edge, predict and compare
  always @(posedge clk) begin
    in_taken <= rst_n && tick_if.valid && tick_if.ready;
    if (rst_n) begin
      if (tick_if.valid && tick_if.ready) begin
        advance_tick(tick_if.encoder_delta);
        ticks_taken++;
      end
      if (report_if.valid && report_if.ready) begin
        if (pending_reports.size() == 0) begin
          flag_mismatch($sformatf("report %0d arrived with nothing expected", reports_seen));
        end else begin
          want_report = pending_reports.pop_front();
          check_field("motor_drive", report_if.motor_drive, want_report.drive);
          check_field("measured_speed", report_if.measured_speed, want_report.speed);
          check_field("measured_position", report_if.measured_position,
                      want_report.position);
          check_field("speed_setpoint", report_if.speed_setpoint, want_report.setpoint);
        end
        reports_seen++;
      end
      // Watchdog: give up when no request moves for too long
      if ((tick_if.valid && tick_if.ready) || (report_if.valid && report_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Queue random ticks around a cruise speed, with full-range noise and extremes
  task automatic push_random(input int count);
    int cruise, r, v;
    @(posedge clk);
    case ($urandom_range(0, 3))
      0, 1: cruise = int'($urandom_range(0, 128)) - 64;
      2: cruise = int'($urandom_range(0, 1200)) - 600;
      default: cruise = int'($urandom_range(0, 4095)) + DELTA_MIN;
    endcase
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        v = cruise + int'($urandom_range(0, 8)) - 4;
      end else if (r < 90) begin
        v = int'($urandom_range(0, 4095)) + DELTA_MIN;
      end else begin
        case ($urandom_range(0, 3))
          0: v = DELTA_MAX;
          1: v = DELTA_MIN;
          2: v = 0;
          default: v = -1;
        endcase
      end
      if (v > DELTA_MAX) v = DELTA_MAX;
      if (v < DELTA_MIN) v = DELTA_MIN;
      pending_ticks.push_back(DELTA_W'(v));
    end
  endtask

  // Wait until every tick is taken and every report is back, then let the back end settle
  task automatic drain();
    do @(posedge clk);
    while (pending_ticks.size() != 0 || tick_if.valid || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [DATA_W-1:0] setting [8];
    int phase_count;
    int r;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SPEED_KP;
    cfg_data = '0;
    tick_if.valid = 1'b0;
    tick_if.encoder_delta = '0;
    report_if.ready = 1'b0;
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    in_taken = 1'b0;
    in_gap = 0;
    out_hold = 0;
    idle_cycles = 0;
    error_count = 0;
    ticks_taken = 0;
    reports_seen = 0;

    // Predictor starts from the reset state
    ctrl_regs[REG_SPEED_KP] = SPEED_KP_RST;
    ctrl_regs[REG_SPEED_KI] = SPEED_KI_RST;
    ctrl_regs[REG_SPEED_KD] = SPEED_KD_RST;
    ctrl_regs[REG_POS_KP] = POS_KP_RST;
    ctrl_regs[REG_POS_KI] = POS_KI_RST;
    ctrl_regs[REG_POS_KD] = POS_KD_RST;
    ctrl_regs[REG_GOAL] = GOAL_RST;
    ctrl_regs[REG_LIMIT] = {1'b0, LIMIT_RST};
    inner_count = 0;
    outer_count = 0;
    speed_sum = '0;
    model_position = '0;
    speed_goal = '0;
    speed_prev_err = '0;
    pos_prev_err = '0;
    speed_int = '0;
    pos_int = '0;

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks at reset gains: field extremes and alternating bit patterns
    foreach (EDGE_DELTAS[i]) pending_ticks.push_back(DELTA_W'(EDGE_DELTAS[i]));
    push_random(140);
    drain();

    phase_count = 1;
    while (ticks_taken < 1000) begin
      // Order: speed kp, ki, kd, pos kp, ki, kd, goal, limit
      case (phase_count)
        1: setting = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                       16'h7FFF, 16'hFFFF};
        2: setting = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                       16'h8000, 16'h0000};
        3: setting = '{16'd4096, 16'd0, 16'hF000, 16'd2048, 16'd0, 16'd8192,
                       16'hFC18, 16'd500};
        4: setting = '{16'd1229, 16'd1229, 16'd0, 16'd1229, 16'd300, 16'd1638,
                       16'd250, 16'd300};
        default: begin
          for (int i = 0; i < 6; i++) begin
            r = $urandom_range(0, 9);
            if (r < 2) setting[i] = '0;
            else if (r < 6) setting[i] = DATA_W'($urandom_range(0, 8191) - 4096);
            else setting[i] = DATA_W'($urandom_range(0, 65535));
          end
          setting[REG_GOAL] = DATA_W'($urandom_range(0, 65535));
          r = $urandom_range(0, 9);
          if (r < 2) setting[REG_LIMIT] = '0;
          else if (r < 4) setting[REG_LIMIT] = 16'hFFFF;
          else if (r < 7) setting[REG_LIMIT] = DATA_W'($urandom_range(0, 2000));
          else setting[REG_LIMIT] = DATA_W'($urandom_range(0, 65535));
        end
      endcase

      // Write all registers while the block is idle; limit keeps its low bits only
      for (int i = 0; i < 8; i++) begin
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= reg_idx_t'(i);
        cfg_data <= setting[i];
        if (reg_idx_t'(i) == REG_LIMIT) ctrl_regs[i] = {1'b0, setting[i][LIMIT_W-1:0]};
        else ctrl_regs[i] = setting[i];
      end
      @(negedge clk) cfg_we <= 1'b0;

      in_gaps_on = $urandom_range(0, 3) != 0;
      out_stalls_on = $urandom_range(0, 3) != 0;
      push_random($urandom_range(60, 300));
      drain();
      phase_count++;
    end

    $display("Covered %0d encoder ticks under %0d gain settings (reset gains included).",
             ticks_taken, phase_count);
    $display("Checked %0d drive reports, %0d field mismatches.", reports_seen, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cpsp_pkg.sv
rtl/cpsp_in_if.sv
rtl/cpsp_out_if.sv
rtl/cpsp_front.sv
rtl/cpsp_queue.sv
rtl/cpsp_back.sv
rtl/cascaded_position_speed_pid.sv
bench/tb.sv
